[hdl/wsp_pkg.sv]
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants of the WAV stream parser.
// ----------------------------------------------------------------------------
package wsp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CHUNK  = 3'd1,
        PH_FMT    = 3'd2,
        PH_SKIP   = 3'd3,
        PH_DATA   = 3'd4,
        PH_DRAIN  = 3'd5
    } t_phase;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_MAGIC     = 3'd0;
    localparam logic [2:0] ERR_FMT_LARGE = 3'd1;
    localparam logic [2:0] ERR_FMT_TRUNC = 3'd2;
    localparam logic [2:0] ERR_MISSING   = 3'd3;
    localparam logic [2:0] ERR_FORMAT    = 3'd4;
    localparam logic [2:0] ERR_SHORT     = 3'd5;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [31:0] RATE_16K    = 32'd16000;
    localparam logic [15:0] BITS_16     = 16'd16;
    localparam logic [15:0] FMT_PCM     = 16'd1;
    localparam logic [15:0] MONO        = 16'd1;
    localparam int unsigned BITS_OFFSET = 14;

    // One result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] sample_value;
        logic [24:0] sample_count;
        logic [2:0]  error_code;
        logic        last_of_run;
    } t_result;

    localparam int unsigned RES_W = $bits(t_result);

    // Up to two results per byte
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_pair;

    localparam int unsigned PAIR_W = $bits(t_pair);

endpackage

[hdl/wsp_front.sv]
// ----------------------------------------------------------------------------
// wsp_front
// Byte parser: walks the RIFF header and chunks, produces up to two results
// per accepted byte as one pair word.
// ----------------------------------------------------------------------------
module wsp_front #(
    parameter int unsigned FMT_MAX_BYTES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_file_byte,
    input  logic                i_end_of_file,
    input  logic [24:0]         i_sample_limit,
    output logic                o_emit,
    output wsp_pkg::t_pair      o_pair
);

    wsp_pkg::t_phase r_phase, n_phase;
    logic [32:0] r_cnt, n_cnt;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [15:0] r_fcode, n_fcode;
    logic [15:0] r_chans, n_chans;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic        r_fseen, n_fseen;
    logic [7:0]  r_low, n_low;
    logic [24:0] r_want, n_want;
    logic [24:0] r_sent, n_sent;

    // Pending results of this byte
    logic        v0, v1;
    wsp_pkg::t_result res0, res1;

    logic [32:0] cnt1;
    logic [32:0] skip_tot;
    logic [31:0] len_asm;
    logic [30:0] avail;
    logic [24:0] sent1;
    logic [2:0]  k;

    function automatic wsp_pkg::t_result mk(input logic [1:0] kd, input logic [15:0] s,
                                            input logic [24:0] c, input logic [2:0] e);
        wsp_pkg::t_result r;
        r.kind = kd;
        r.sample_value = s;
        r.sample_count = c;
        r.error_code = e;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    assign cnt1     = r_cnt + 33'd1;
    assign skip_tot = {1'b0, r_len} + {32'd0, r_len[0]};
    assign sent1    = r_sent + 25'd1;
    assign k        = r_cnt[2:0];

    // Byte handling
    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_tag = r_tag; n_len = r_len;
        n_fcode = r_fcode; n_chans = r_chans; n_rate = r_rate; n_bits = r_bits;
        n_fseen = r_fseen; n_low = r_low; n_want = r_want; n_sent = r_sent;
        v0 = 1'b0; v1 = 1'b0;
        res0 = mk(wsp_pkg::KIND_SAMPLE, '0, '0, '0);
        res1 = res0;
        len_asm = r_len;
        avail = '0;
        unique case (r_phase)
            wsp_pkg::PH_HEADER: begin
                if (r_cnt < 33'd4 || r_cnt >= 33'd8) n_tag = {r_tag[23:0], i_file_byte};
                n_cnt = cnt1;
                if (r_cnt == 33'd3 && n_tag != wsp_pkg::TAG_RIFF) begin
                    n_phase = wsp_pkg::PH_DRAIN; v0 = 1'b1;
                    res0 = mk(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_MAGIC);
                end else if (r_cnt == 33'd11) begin
                    if (n_tag != wsp_pkg::TAG_WAVE) begin
                        n_phase = wsp_pkg::PH_DRAIN; v0 = 1'b1;
                        res0 = mk(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_MAGIC);
                    end else begin
                        n_phase = wsp_pkg::PH_CHUNK; n_cnt = '0; n_tag = '0; n_len = '0;
                    end
                end
            end
            wsp_pkg::PH_CHUNK: begin
                if (r_cnt < 33'd4) n_tag = {r_tag[23:0], i_file_byte};
                else if (r_cnt < 33'd8) begin
                    case (k[1:0])
                        2'd0: len_asm[7:0]   = i_file_byte;
                        2'd1: len_asm[15:8]  = i_file_byte;
                        2'd2: len_asm[23:16] = i_file_byte;
                        default: len_asm[31:24] = i_file_byte;
                    endcase
                end
                n_len = len_asm;
                n_cnt = cnt1;
                if (cnt1 == 33'd8) begin
                    n_cnt = '0;
                    if (r_tag == wsp_pkg::TAG_FMT) begin
                        if (len_asm > 32'(FMT_MAX_BYTES)) begin
                            n_phase = wsp_pkg::PH_DRAIN; v0 = 1'b1;
                            res0 = mk(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_FMT_LARGE);
                        end else begin
                            n_fcode = '0; n_chans = '0; n_rate = '0; n_bits = '0;
                            if (len_asm == '0) begin
                                n_fseen = 1'b1;
                                n_phase = wsp_pkg::PH_CHUNK; n_tag = '0; n_len = '0;
                            end else begin
                                n_phase = wsp_pkg::PH_FMT;
                            end
                        end
                    end else if (r_tag == wsp_pkg::TAG_DATA) begin
                        avail = len_asm[31:1];
                        if (!r_fseen) begin
                            n_phase = wsp_pkg::PH_DRAIN; v0 = 1'b1;
                            res0 = mk(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_MISSING);
                        end else if (r_fcode != wsp_pkg::FMT_PCM || r_chans != wsp_pkg::MONO ||
                                     r_rate != wsp_pkg::RATE_16K ||
                                     r_bits != wsp_pkg::BITS_16) begin
                            n_phase = wsp_pkg::PH_DRAIN; v0 = 1'b1;
                            res0 = mk(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_FORMAT);
                        end else begin
                            n_want = (avail < {6'd0, i_sample_limit}) ? avail[24:0]
                                                                      : i_sample_limit;
                            n_sent = '0;
                            if (n_want == '0) begin
                                n_phase = wsp_pkg::PH_DRAIN; v0 = 1'b1;
                                res0 = mk(wsp_pkg::KIND_DONE, '0, '0, '0);
                            end else begin
                                n_phase = wsp_pkg::PH_DATA;
                            end
                        end
                    end else begin
                        if ({1'b0, len_asm} + {32'd0, len_asm[0]} == 33'd0) begin
                            n_phase = wsp_pkg::PH_CHUNK; n_tag = '0; n_len = '0;
                        end else begin
                            n_phase = wsp_pkg::PH_SKIP;
                        end
                    end
                end
            end
            wsp_pkg::PH_FMT: begin
                if (r_cnt < 33'd8) begin
                    case (k)
                        3'd0: n_fcode[7:0]  = i_file_byte;
                        3'd1: n_fcode[15:8] = i_file_byte;
                        3'd2: n_chans[7:0]  = i_file_byte;
                        3'd3: n_chans[15:8] = i_file_byte;
                        3'd4: n_rate[7:0]   = i_file_byte;
                        3'd5: n_rate[15:8]  = i_file_byte;
                        3'd6: n_rate[23:16] = i_file_byte;
                        default: n_rate[31:24] = i_file_byte;
                    endcase
                end else if (r_cnt == 33'(wsp_pkg::BITS_OFFSET)) begin
                    n_bits[7:0] = i_file_byte;
                end else if (r_cnt == 33'(wsp_pkg::BITS_OFFSET + 1)) begin
                    n_bits[15:8] = i_file_byte;
                end
                n_cnt = cnt1;
                if (cnt1 >= {1'b0, r_len}) begin
                    n_fseen = 1'b1;
                    if (r_len[0]) begin
                        n_phase = wsp_pkg::PH_SKIP; n_cnt = {1'b0, r_len};
                    end else begin
                        n_phase = wsp_pkg::PH_CHUNK; n_cnt = '0; n_tag = '0; n_len = '0;
                    end
                end
            end
            wsp_pkg::PH_SKIP: begin
                n_cnt = cnt1;
                if (cnt1 >= skip_tot) begin
                    n_phase = wsp_pkg::PH_CHUNK; n_cnt = '0; n_tag = '0; n_len = '0;
                end
            end
            wsp_pkg::PH_DATA: begin
                if (!r_cnt[0]) begin
                    n_low = i_file_byte;
                end else begin
                    v0 = 1'b1;
                    res0 = mk(wsp_pkg::KIND_SAMPLE, {i_file_byte, r_low}, '0, '0);
                    n_sent = sent1;
                    if (sent1 >= r_want) begin
                        n_phase = wsp_pkg::PH_DRAIN; v1 = 1'b1;
                        res1 = mk(wsp_pkg::KIND_DONE, '0, sent1, '0);
                    end
                end
                n_cnt = {32'd0, ~r_cnt[0]};
            end
            default: ;
        endcase

        // End of file: report if mid-stream, then re-arm
        if (i_end_of_file) begin
            if (n_phase != wsp_pkg::PH_DRAIN) begin
                if (v0) begin
                    v1 = 1'b1;
                    res1 = mk(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_SHORT);
                end else begin
                    v0 = 1'b1;
                    unique case (n_phase)
                        wsp_pkg::PH_HEADER:
                            res0 = mk(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_MAGIC);
                        wsp_pkg::PH_FMT:
                            res0 = mk(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_FMT_TRUNC);
                        wsp_pkg::PH_DATA:
                            res0 = mk(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_SHORT);
                        default:
                            res0 = mk(wsp_pkg::KIND_ERROR, '0, '0, wsp_pkg::ERR_MISSING);
                    endcase
                end
            end
            n_phase = wsp_pkg::PH_HEADER; n_cnt = '0; n_tag = '0; n_len = '0;
            n_fcode = '0; n_chans = '0; n_rate = '0; n_bits = '0; n_fseen = 1'b0;
            n_low = '0; n_want = '0; n_sent = '0;
        end
    end

    // Pair assembly: last_of_run on the final entry
    always_comb begin
        o_emit = i_valid && v0;
        o_pair.two = v1;
        o_pair.r0 = res0;
        o_pair.r1 = res1;
        o_pair.r0.last_of_run = ~v1;
        o_pair.r1.last_of_run = 1'b1;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wsp_pkg::PH_HEADER;
            r_cnt <= '0; r_tag <= '0; r_len <= '0; r_fcode <= '0; r_chans <= '0;
            r_rate <= '0; r_bits <= '0; r_fseen <= 1'b0; r_low <= '0;
            r_want <= '0; r_sent <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_cnt <= n_cnt; r_tag <= n_tag; r_len <= n_len; r_fcode <= n_fcode;
            r_chans <= n_chans; r_rate <= n_rate; r_bits <= n_bits;
            r_fseen <= n_fseen; r_low <= n_low; r_want <= n_want; r_sent <= n_sent;
        end
    end

endmodule

[hdl/wsp_back.sv]
// ----------------------------------------------------------------------------
// wsp_back
// Result queue: holds pair words and hands out their results one at a time.
// ----------------------------------------------------------------------------
module wsp_back #(
    parameter int unsigned DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wsp_pkg::t_pair     i_pair,
    output logic               o_full,
    output logic               o_empty,
    input  logic               i_pop,
    output wsp_pkg::t_result   o_result
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    wsp_pkg::t_pair r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt, n_cnt;
    logic          r_half;
    logic          do_pop, pair_done;
    wsp_pkg::t_pair head;

    assign head      = r_mem[r_rp];
    assign o_full    = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_result  = r_half ? head.r1 : head.r0;
    assign do_pop    = i_pop && !o_empty;
    assign pair_done = do_pop && (r_half || !head.two);

    always_comb begin
        n_cnt = r_cnt + (AW+1)'(i_push) - (AW+1)'(pair_done);
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_pair;
    end

    // Pointers and half select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_half <= 1'b0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (pair_done) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
                r_half <= 1'b0;
            end else if (do_pop) begin
                r_half <= 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

[hdl/wav_stream_parser.sv]
// ----------------------------------------------------------------------------
// wav_stream_parser
// Byte-serial RIFF/WAVE reader for 16-bit PCM mono 16 kHz streams.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_file_byte / i_end_of_file, raise push; the word
//   is taken at an edge where full is low. One byte per cycle while not full.
//   Result channel: while empty is low the oldest result is on the o_
//   ports; raise pop to take it. A byte gives at most two results.
//   A byte's results are written to the queue at the edge accepting it.
//   The parser front updates its state in the accepting cycle; results go
//   into a four-entry queue of pairs, so the front only stalls (full) when
//   the queue is full because the receiver is not popping.
//   Configuration: i_cfg_valid/o_cfg_ready write the sample limit; ready is
//   high always, write only when idle.
//   Reset (synchronous, i_rst_n low) clears the parser to the header phase,
//   empties the queue and sets the sample limit to 16000.
// ----------------------------------------------------------------------------
module wav_stream_parser #(
    parameter int unsigned FMT_MAX_BYTES = 32,
    parameter int unsigned QUEUE_DEPTH   = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_file_byte,
    input  logic               i_end_of_file,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_sample_value,
    output logic [24:0]        o_sample_count,
    output logic [2:0]         o_error_code,
    output logic               o_last_of_run,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [24:0]        i_cfg_data
);

    logic [24:0] r_sample_limit;
    logic        acc, emit;
    wsp_pkg::t_pair   pair;
    wsp_pkg::t_result res;

    assign acc = push && !full;
    assign o_cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sample_limit <= 25'd16000;
        else if (i_cfg_valid) r_sample_limit <= i_cfg_data;
    end

    wsp_front #(.FMT_MAX_BYTES(FMT_MAX_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid(acc), .i_file_byte, .i_end_of_file,
        .i_sample_limit(r_sample_limit), .o_emit(emit), .o_pair(pair)
    );

    wsp_back #(.DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_push(emit), .i_pair(pair), .o_full(full),
        .o_empty(empty), .i_pop(pop), .o_result(res)
    );

    assign o_kind         = res.kind;
    assign o_sample_value = res.sample_value;
    assign o_sample_count = res.sample_count;
    assign o_error_code   = res.error_code;
    assign o_last_of_run  = res.last_of_run;

    // Checks
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_kind != 2'd3)) else $error("illegal result kind");
    a_push_into_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !full) else $error("push into full queue");
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == wsp_pkg::KIND_ERROR) |-> (o_error_code <= wsp_pkg::ERR_SHORT))
        else $error("bad error code");

endmodule
